### sv/htlp_pkg.sv
// Shared types, codes and constants for the hex trace line parser.
`default_nettype none
package htlp_pkg;

  // Segment limit and counter width
  localparam int MAX_SEGMENT = 8192;
  localparam int CNT_W       = $clog2(MAX_SEGMENT + 1);
  localparam int LEN_W       = 14;

  // Parser state codes
  localparam logic [3:0] PS_BASE   = 4'd0;
  localparam logic [3:0] PS_WRONG  = 4'd1;
  localparam logic [3:0] PS_LESS   = 4'd2;
  localparam logic [3:0] PS_SPACE  = 4'd3;
  localparam logic [3:0] PS_ZERO   = 4'd4;
  localparam logic [3:0] PS_X      = 4'd5;
  localparam logic [3:0] PS_N      = 4'd6;
  localparam logic [3:0] PS_SPACE2 = 4'd7;
  localparam logic [3:0] PS_D1     = 4'd8;
  localparam logic [3:0] PS_D2     = 4'd9;

  // Step modes
  localparam logic [1:0] MODE_LINE = 2'd0;
  localparam logic [1:0] MODE_EOR  = 2'd1;
  localparam logic [1:0] MODE_MARK = 2'd2;
  localparam logic [1:0] MODE_BIDI = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_GREAT = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // Telnet codes
  localparam logic [7:0] TEL_IAC = 8'hFF;
  localparam logic [7:0] TEL_EOR = 8'hEF;

  // Parser state carried between characters
  typedef struct packed {
    logic [3:0]       pstate;
    logic             iac_seen;
    logic [3:0]       high_nibble;
    logic [CNT_W-1:0] byte_count;
    logic             direction;
  } parse_t;

  // One result item
  typedef struct packed {
    logic             byte_valid;
    logic [7:0]       data_byte;
    logic             from_emulator;
    logic             segment_end;
    logic [LEN_W-1:0] segment_length;
    logic             step_done;
    logic             reached_mark;
    logic             bad_hex;
    logic             at_eof;
  } result_t;

  // Lowercase hex digit decode: bit 4 set when not a digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/htlp_step.sv
// Next-state and result logic of the parser for one character.
`default_nettype none
module htlp_step (
  input  wire logic [1:0]       step_mode,
  input  wire htlp_pkg::parse_t cur,
  input  wire logic [7:0]       text_char,
  input  wire logic             end_of_input,
  input  wire logic             restart,
  output htlp_pkg::parse_t      nxt,
  output htlp_pkg::result_t     res
);
  import htlp_pkg::*;

  parse_t     s;
  logic [4:0] hv;
  logic       is_hex;
  logic       is_ws;
  logic       fail;
  logic       ends;
  logic       eor;
  logic [7:0] db;
  logic [CNT_W-1:0] cnt_inc;

  assign hv      = hex_value(text_char);
  assign is_hex  = !hv[4];
  assign is_ws   = (text_char == CH_SPACE) || (text_char == CH_TAB);
  assign db      = {cur.high_nibble, hv[3:0]};
  assign cnt_inc = s.byte_count + CNT_W'(1);

  always_comb begin
    // Apply restart, then force host direction outside bidirectional mode
    s = cur;
    if (restart) begin
      s = '0;
      s.pstate = PS_BASE;
    end
    if (step_mode != MODE_BIDI) s.direction = 1'b0;

    nxt  = s;
    res  = '0;
    fail = 1'b0;
    ends = 1'b0;
    eor  = 1'b0;

    if (end_of_input) begin
      res.at_eof    = 1'b1;
      res.step_done = 1'b1;
    end else if (text_char != CH_CR) begin
      unique case (s.pstate)
        PS_BASE: begin
          if (text_char == CH_PLUS && step_mode == MODE_MARK) begin
            ends             = 1'b1;
            res.step_done    = 1'b1;
            res.reached_mark = 1'b1;
          end else if (text_char == CH_LESS) begin
            nxt.direction = 1'b0;
            nxt.pstate    = PS_LESS;
          end else if (text_char == CH_GREAT && step_mode == MODE_BIDI) begin
            nxt.direction = 1'b1;
            nxt.pstate    = PS_LESS;
          end else begin
            fail = 1'b1;
          end
        end
        PS_LESS: begin
          if (text_char == CH_SPACE) nxt.pstate = PS_SPACE; else fail = 1'b1;
        end
        PS_SPACE: begin
          if (text_char == CH_ZERO) nxt.pstate = PS_ZERO; else fail = 1'b1;
        end
        PS_ZERO: begin
          if (text_char == CH_X) nxt.pstate = PS_X; else fail = 1'b1;
        end
        PS_X: begin
          if (is_hex) nxt.pstate = PS_N; else fail = 1'b1;
        end
        PS_N: begin
          if (is_hex) nxt.pstate = PS_N;
          else if (is_ws) nxt.pstate = PS_SPACE2;
          else fail = 1'b1;
        end
        PS_SPACE2: begin
          if (is_hex) begin
            nxt.high_nibble = hv[3:0];
            nxt.byte_count  = '0;
            nxt.pstate      = PS_D1;
          end else if (!is_ws) begin
            fail = 1'b1;
          end
        end
        PS_D1: begin
          if (is_hex) begin
            res.byte_valid = 1'b1;
            res.data_byte  = db;
            nxt.pstate     = PS_D2;
            // Track telnet IAC so that IAC EOR can end a segment
            if (!s.iac_seen) begin
              nxt.iac_seen = (db == TEL_IAC);
            end else begin
              eor          = (db == TEL_EOR) && (step_mode == MODE_EOR);
              nxt.iac_seen = 1'b0;
            end
            nxt.byte_count = cnt_inc;
            if (eor || cnt_inc >= CNT_W'(MAX_SEGMENT)) begin
              ends = 1'b1;
              if (eor || step_mode == MODE_LINE) res.step_done = 1'b1;
            end
          end else begin
            res.bad_hex = 1'b1;
            fail        = 1'b1;
          end
        end
        PS_D2: begin
          if (is_hex) begin
            nxt.high_nibble = hv[3:0];
            nxt.pstate      = PS_D1;
          end else if (text_char == CH_LF) begin
            nxt.pstate = PS_BASE;
            ends       = 1'b1;
            if (step_mode == MODE_LINE) res.step_done = 1'b1;
          end else begin
            res.bad_hex = 1'b1;
            fail        = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase

      // Skip a malformed line up to its newline
      if (nxt.pstate == PS_WRONG || fail)
        nxt.pstate = (text_char == CH_LF) ? PS_BASE : PS_WRONG;

      // End the segment and start an empty one
      if (ends) begin
        res.segment_end    = 1'b1;
        res.segment_length = LEN_W'(nxt.byte_count);
        nxt.byte_count     = '0;
      end
    end

    res.from_emulator = nxt.direction;
  end

endmodule
`default_nettype wire

### sv/hex_trace_line_parser.sv
// Top level of the hex trace line parser: stream ports, state and result register.
// The result of an accepted character is held in the output register from the next cycle.
// Throughput: one character per cycle; a new request is taken whenever the output
// register is empty or its result is taken in the same cycle.
// Reset (rst_n low, synchronous): line start, host direction, empty segment,
// no IAC seen, step_mode 0, output register empty.
`default_nettype none
module hex_trace_line_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: step_mode in cfg_data[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_char
  input  wire logic        in_tlast,   // end_of_input
  input  wire logic        in_tuser,   // restart
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] data_byte, [21:8] segment_length, zero pad
  output logic             out_tlast,  // segment_end
  output logic [5:0]       out_tuser   // byte_valid, from_emulator, step_done,
                                       // reached_mark, bad_hex, at_eof
);
  import htlp_pkg::*;

  logic [1:0] mode_r;
  parse_t     state_r;
  parse_t     state_nxt;
  result_t    res_nxt;
  result_t    res_r;
  logic       out_valid_r;
  logic       in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  htlp_step u_step (
    .step_mode    (mode_r),
    .cur          (state_r),
    .text_char    (in_tdata),
    .end_of_input (in_tlast),
    .restart      (in_tuser),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  // Hold the step mode register
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_LINE;
    else if (cfg_valid && cfg_ready) mode_r <= cfg_data;
  end

  // Advance the parser state on each accepted request; all-zero is line start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (in_acc) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.segment_length, res_r.data_byte};
  assign out_tlast  = res_r.segment_end;
  assign out_tuser  = {res_r.at_eof, res_r.bad_hex, res_r.reached_mark,
                       res_r.step_done, res_r.from_emulator, res_r.byte_valid};

endmodule
`default_nettype wire

### sim/hex_trace_line_parser_test.sv
`timescale 1ns / 100ps
// Testbench for the hex trace line parser: drives trace text and checks each result.
module hex_trace_line_parser_test;
  import htlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_CHARS    = 95;

  // One character request as the sender presents it
  typedef struct {
    logic [7:0] ch;
    logic       eof;
    logic       rst;
  } trace_char_t;

  // Parser model plus the queue of results it expects
  class trace_scoreboard;
    logic [1:0]  mode;
    logic [3:0]  pstate;
    logic        iac_seen;
    logic [3:0]  high_nib;
    int unsigned count;
    logic        dir;
    result_t     expected_results[$];
    int          errors, checked, seg_ends, marks, bad_digits, eofs;

    function new();
      mode = MODE_LINE;
      clear_parser();
      errors = 0;
      checked = 0;
      seg_ends = 0;
      marks = 0;
      bad_digits = 0;
      eofs = 0;
    endfunction

    function void clear_parser();
      pstate = PS_BASE;
      iac_seen = 1'b0;
      high_nib = 4'd0;
      count = 0;
      dir = 1'b0;
    endfunction

    // Lowercase hex digit value; bit 4 flags anything else
    function logic [4:0] digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      return 5'd16;
    endfunction

    // Advance the parser by one accepted request and queue its result
    function void note_request(trace_char_t t);
      result_t    r;
      logic [4:0] hv;
      logic [7:0] b;
      logic       fail, ends, eor, blank;
      r = '0;
      fail = 1'b0;
      ends = 1'b0;
      eor = 1'b0;
      if (t.rst) clear_parser();
      if (mode != MODE_BIDI) dir = 1'b0;
      if (t.eof) begin
        r.at_eof = 1'b1;
        r.step_done = 1'b1;
      end else if (t.ch != CH_CR) begin
        hv = digit_value(t.ch);
        blank = (t.ch == CH_SPACE) || (t.ch == CH_TAB);
        case (pstate)
          PS_BASE: begin
            if (t.ch == CH_PLUS && mode == MODE_MARK) begin
              ends = 1'b1;
              r.step_done = 1'b1;
              r.reached_mark = 1'b1;
            end else if (t.ch == CH_LESS) begin
              dir = 1'b0;
              pstate = PS_LESS;
            end else if (t.ch == CH_GREAT && mode == MODE_BIDI) begin
              dir = 1'b1;
              pstate = PS_LESS;
            end else begin
              fail = 1'b1;
            end
          end
          PS_LESS:  if (t.ch == CH_SPACE) pstate = PS_SPACE; else fail = 1'b1;
          PS_SPACE: if (t.ch == CH_ZERO) pstate = PS_ZERO; else fail = 1'b1;
          PS_ZERO:  if (t.ch == CH_X) pstate = PS_X; else fail = 1'b1;
          PS_X:     if (!hv[4]) pstate = PS_N; else fail = 1'b1;
          PS_N: begin
            if (hv[4]) begin
              if (blank) pstate = PS_SPACE2; else fail = 1'b1;
            end
          end
          PS_SPACE2: begin
            if (!hv[4]) begin
              high_nib = hv[3:0];
              count = 0;
              pstate = PS_D1;
            end else if (!blank) begin
              fail = 1'b1;
            end
          end
          PS_D1: begin
            if (!hv[4]) begin
              b = {high_nib, hv[3:0]};
              r.byte_valid = 1'b1;
              r.data_byte = b;
              pstate = PS_D2;
              // IAC followed by EOR closes a record in EOR mode
              if (!iac_seen) begin
                iac_seen = (b == TEL_IAC);
              end else begin
                eor = (b == TEL_EOR) && (mode == MODE_EOR);
                iac_seen = 1'b0;
              end
              count++;
              if (eor || count >= MAX_SEGMENT) begin
                ends = 1'b1;
                if (eor || mode == MODE_LINE) r.step_done = 1'b1;
              end
            end else begin
              r.bad_hex = 1'b1;
              fail = 1'b1;
            end
          end
          PS_D2: begin
            if (!hv[4]) begin
              high_nib = hv[3:0];
              pstate = PS_D1;
            end else if (t.ch == CH_LF) begin
              pstate = PS_BASE;
              ends = 1'b1;
              if (mode == MODE_LINE) r.step_done = 1'b1;
            end else begin
              r.bad_hex = 1'b1;
              fail = 1'b1;
            end
          end
          default: fail = 1'b1;
        endcase
        // Skip the rest of a malformed line
        if (pstate == PS_WRONG || fail) pstate = (t.ch == CH_LF) ? PS_BASE : PS_WRONG;
        if (ends) begin
          r.segment_end = 1'b1;
          r.segment_length = LEN_W'(count);
          count = 0;
        end
      end
      r.from_emulator = dir;
      expected_results.push_back(r);
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic [23:0] tdata, logic tlast, logic [5:0] tuser);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none actual %h/%b/%b",
                 $time, tdata, tlast, tuser);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want.segment_end) seg_ends++;
      if (want.reached_mark) marks++;
      if (want.bad_hex) bad_digits++;
      if (want.at_eof) eofs++;
      field_check("byte_valid", want.byte_valid, tuser[0]);
      field_check("data_byte", want.data_byte, tdata[7:0]);
      field_check("from_emulator", want.from_emulator, tuser[1]);
      field_check("segment_end", want.segment_end, tlast);
      field_check("segment_length", want.segment_length, tdata[21:8]);
      field_check("step_done", want.step_done, tuser[2]);
      field_check("reached_mark", want.reached_mark, tuser[3]);
      field_check("bad_hex", want.bad_hex, tuser[4]);
      field_check("at_eof", want.at_eof, tuser[5]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [5:0]  out_tuser;

  trace_scoreboard sb;
  trace_char_t     char_q[$];
  string           hex_digits = "0123456789abcdef";
  int              burst_left = 0;
  int              chars_sent = 0;
  int              idle_cycles = 0;
  int              hold_asked = 0;
  int              hold_seen = 0;

  hex_trace_line_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Check results and watch for a stuck run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no request moved for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: changing stall styles, plus a long hold-off on request
  initial begin : rx_side
    int hold_left;
    int style;
    int style_left;
    int rx_cycle;
    hold_left = 0;
    style = 0;
    style_left = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ((rx_cycle % 5) < 2);
          default: out_tready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Offer one character in bursts with random gaps; note it once accepted
  task automatic send_char(input trace_char_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= t.ch;
    in_tlast <= t.eof;
    in_tuser <= t.rst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(t);
    chars_sent++;
  endtask

  // Stop offering and hold until every expected result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.mode = m;
  endtask

  task automatic push_char(input logic [7:0] c, input logic eof, input logic rst);
    trace_char_t t;
    t.ch = c;
    t.eof = eof;
    t.rst = rst;
    char_q.push_back(t);
  endtask

  task automatic push_str(input string s);
    foreach (s[i]) push_char(s[i], 1'b0, 1'b0);
  endtask

  // Build one trace line: mostly well formed, some noise, marks and corruption
  task automatic gen_line(input logic [1:0] m);
    logic [7:0] line_q[$];
    logic [7:0] bytes_q[$];
    int         kind, n, sel, pos;
    kind = $urandom_range(0, 99);
    if (m == MODE_MARK && kind < 15) begin
      line_q.push_back(CH_PLUS);
      if ($urandom_range(0, 1)) line_q.push_back(CH_LF);
    end else if (kind < 25) begin
      n = $urandom_range(1, 8);
      repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_LF);
    end else begin
      if (m == MODE_BIDI) line_q.push_back($urandom_range(0, 1) ? CH_GREAT : CH_LESS);
      else line_q.push_back(($urandom_range(0, 19) == 0) ? CH_GREAT : CH_LESS);
      line_q.push_back(CH_SPACE);
      line_q.push_back(CH_ZERO);
      line_q.push_back(CH_X);
      repeat ($urandom_range(1, 4)) line_q.push_back(hex_digits[$urandom_range(0, 15)]);
      repeat ($urandom_range(1, 2)) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          bytes_q.push_back(TEL_IAC);
          bytes_q.push_back(TEL_EOR);
        end else if (sel == 1) begin
          bytes_q.push_back(TEL_IAC);
          bytes_q.push_back(TEL_IAC);
        end else begin
          bytes_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (bytes_q[i]) begin
        line_q.push_back(hex_digits[bytes_q[i][7:4]]);
        line_q.push_back(hex_digits[bytes_q[i][3:0]]);
      end
      // Damage some lines: lone digit, stray byte, uppercase or NUL, or an inserted CR
      sel = $urandom_range(0, 7);
      pos = $urandom_range(0, line_q.size() - 1);
      case (sel)
        0: void'(line_q.pop_back());
        1: line_q[pos] = 8'($urandom_range(0, 255));
        2: line_q[pos] = $urandom_range(0, 1) ? 8'h00 : 8'(8'h41 + $urandom_range(0, 5));
        3: line_q.insert(pos, CH_CR);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end
    foreach (line_q[i])
      push_char(line_q[i], $urandom_range(0, 79) == 0, $urandom_range(0, 59) == 0);
  endtask

  task automatic send_queued(input bit with_hold);
    int k;
    k = 0;
    while (char_q.size() != 0) begin
      if (with_hold && k == 15) hold_asked++;
      send_char(char_q.pop_front());
      k++;
    end
  endtask

  task automatic run_phase(input logic [1:0] m, input bit with_hold);
    write_mode(m);
    while (char_q.size() < PHASE_CHARS) gen_line(m);
    send_queued(with_hold);
  endtask

  initial begin
    logic [1:0] phase_modes[8];
    sb = new();
    phase_modes = '{MODE_EOR, MODE_MARK, MODE_BIDI, MODE_LINE,
                    MODE_BIDI, MODE_MARK, MODE_EOR, MODE_LINE};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes with tab and CR, NUL line, end of input,
    // restart, and a lone digit before the newline
    write_mode(MODE_LINE);
    push_str("< 0xf\t00ff\r\n");
    push_char(8'h00, 1'b0, 1'b0);
    push_char(CH_LF, 1'b0, 1'b0);
    push_char("z", 1'b1, 1'b0);
    push_char(CH_LESS, 1'b0, 1'b1);
    push_str(" 0x1 7\n");
    send_queued(1'b0);

    // Random phases over all step modes; the third one holds the receiver off
    foreach (phase_modes[i]) run_phase(phase_modes[i], i == 2);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters over all four step modes; %0d results checked.",
             chars_sent, sb.checked);
    $display("Seen %0d segment ends, %0d marks, %0d bad digits, %0d end-of-input items.",
             sb.seg_ends, sb.marks, sb.bad_digits, sb.eofs);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
